[rtl/phi_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the position history interpolator.
// No dependencies; imported by every module of the block but phi_ram.
package phi_pkg;

    // Field widths fixed by the item format
    localparam int unsigned TIME_W = 63;
    localparam int unsigned POS_W  = 32;
    localparam int unsigned ENTRY_W = TIME_W + POS_W;

    // Default store depth
    localparam int unsigned HISTORY_DEPTH_DEF = 64;

    // Bisection stops once the span is this small, then a linear scan runs
    localparam int unsigned SPAN_LIMIT = 16;

    // Width of the interpolation magnitude and quotient (|pb - pa| < 2^33)
    localparam int unsigned MAG_W  = POS_W + 1;
    localparam int unsigned PROD_W = TIME_W + MAG_W;

    // Command codes
    localparam logic [1:0] CMD_APPEND  = 2'd0;
    localparam logic [1:0] CMD_LOOKUP  = 2'd1;
    localparam logic [1:0] CMD_FIND    = 2'd2;
    localparam logic [1:0] CMD_DISCARD = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_BAD_DELTA = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // One classified command beat, as queued between front and back
    typedef struct packed {
        logic [1:0]              kind;
        logic [TIME_W-1:0]       entry_time;
        logic signed [POS_W-1:0] entry_position;
        logic [TIME_W-1:0]       query_time;
    } op_t;

endpackage

[rtl/position_history_interpolator.sv]
`timescale 1ns / 1ps
// Top level of the position history interpolator.
// Depends on phi_pkg, phi_front, phi_back (and phi_ram beneath it).
//
// Keeps up to HISTORY_DEPTH (time, position) entries in a ring store and
// answers one result beat per command beat. Commands queue two deep in
// front of a sequencer, so the command side keeps moving while a result
// waits. The single read port of the store and the bit-serial arithmetic
// set the time per command: an append writes the store on dispatch; a find
// reads the entries in order up to the found index, one further when a
// later entry ends the search; a lookup reads the newest and oldest
// entries, then bisects to a span of SPAN_LIMIT or less; one that
// interpolates adds a linear scan, the 33-step multiply and 33-step divide.
module position_history_interpolator #(
    parameter int unsigned HISTORY_DEPTH = phi_pkg::HISTORY_DEPTH_DEF,
    parameter int unsigned CNT_W = $clog2(HISTORY_DEPTH + 1)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_valid,
    output logic                             cmd_stall,
    input  logic [1:0]                       command,
    input  logic [phi_pkg::TIME_W-1:0]       entry_time,
    input  logic signed [phi_pkg::POS_W-1:0] entry_position,
    input  logic [phi_pkg::TIME_W-1:0]       query_time,
    output logic                             result_valid,
    input  logic                             result_stall,
    output logic [1:0]                       status,
    output logic signed [phi_pkg::POS_W-1:0] result_position,
    output logic [phi_pkg::TIME_W-1:0]       result_time,
    output logic [CNT_W-1:0]                 found_index,
    output logic [CNT_W-1:0]                 entry_count
);
    import phi_pkg::*;

    logic head_valid;
    op_t  head;
    logic pop;

    phi_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd_stall      (cmd_stall),
        .command        (command),
        .entry_time     (entry_time),
        .entry_position (entry_position),
        .query_time     (query_time),
        .head_valid     (head_valid),
        .head           (head),
        .pop            (pop)
    );

    phi_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .IDX_W         ($clog2(HISTORY_DEPTH)),
        .CNT_W         (CNT_W)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_valid      (head_valid),
        .head            (head),
        .pop             (pop),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .status          (status),
        .result_position (result_position),
        .result_time     (result_time),
        .found_index     (found_index),
        .entry_count     (entry_count)
    );

endmodule

[rtl/phi_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module phi_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/phi_front.sv]
`timescale 1ns / 1ps
// Front end: accepts command beats, classifies them and holds them in a
// two-entry queue for the back end. Depends on phi_pkg.
module phi_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    output logic                         cmd_stall,
    input  logic [1:0]                   command,
    input  logic [phi_pkg::TIME_W-1:0]   entry_time,
    input  logic signed [phi_pkg::POS_W-1:0] entry_position,
    input  logic [phi_pkg::TIME_W-1:0]   query_time,
    output logic                         head_valid,
    output phi_pkg::op_t                 head,
    input  logic                         pop
);
    import phi_pkg::*;

    op_t        ops_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic       push;
    op_t        op_in;

    // Classify the incoming beat
    always_comb
    begin
        op_in.kind           = command;
        op_in.entry_time     = entry_time;
        op_in.entry_position = entry_position;
        op_in.query_time     = query_time;
        unique case (command)
            CMD_APPEND:
            begin
                op_in.query_time = '0;
            end
            CMD_LOOKUP, CMD_FIND, CMD_DISCARD:
            begin
                op_in.entry_time     = '0;
                op_in.entry_position = '0;
            end
            default:
            begin
                op_in.kind = command;
            end
        endcase
    end

    assign cmd_stall  = (fill_reg == 2'd2);
    assign push       = cmd_valid && !cmd_stall;
    assign head_valid = (fill_reg != 2'd0);
    assign head       = ops_reg[rd_ptr_reg];

    // Queue payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ops_reg[wr_ptr_reg] <= op_in;
        end
    end

    // Queue pointers and fill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

[rtl/phi_back.sv]
`timescale 1ns / 1ps
// Back end: sequencer that owns the history store, runs append, lookup
// (bisection, scan, serial multiply and divide), find and discard. Uses phi_pkg, phi_ram.
module phi_back #(
    parameter int unsigned HISTORY_DEPTH = phi_pkg::HISTORY_DEPTH_DEF,
    parameter int unsigned IDX_W = $clog2(HISTORY_DEPTH),
    parameter int unsigned CNT_W = $clog2(HISTORY_DEPTH + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         head_valid,
    input  phi_pkg::op_t                 head,
    output logic                         pop,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic [1:0]                   status,
    output logic signed [phi_pkg::POS_W-1:0] result_position,
    output logic [phi_pkg::TIME_W-1:0]   result_time,
    output logic [CNT_W-1:0]             found_index,
    output logic [CNT_W-1:0]             entry_count
);
    import phi_pkg::*;

    localparam logic [IDX_W:0] DEPTH_V = (IDX_W + 1)'(HISTORY_DEPTH);
    localparam logic [CNT_W-1:0] FULL_V = CNT_W'(HISTORY_DEPTH);
    localparam int unsigned STEP_W = $clog2(MAG_W + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_L_NEW  = 4'd1;
    localparam logic [3:0] S_L_OLD  = 4'd2;
    localparam logic [3:0] S_L_BIS  = 4'd3;
    localparam logic [3:0] S_L_MID  = 4'd4;
    localparam logic [3:0] S_L_HIT  = 4'd5;
    localparam logic [3:0] S_L_SC0  = 4'd6;
    localparam logic [3:0] S_L_SC   = 4'd7;
    localparam logic [3:0] S_MUL    = 4'd8;
    localparam logic [3:0] S_DIV    = 4'd9;
    localparam logic [3:0] S_INTERP = 4'd10;
    localparam logic [3:0] S_F_FST  = 4'd11;
    localparam logic [3:0] S_F_NXT  = 4'd12;
    localparam logic [3:0] S_FIN    = 4'd13;

    logic [3:0]              state_reg, state_next;
    logic [1:0]              cmd_reg, cmd_next;
    logic [TIME_W-1:0]       q_reg, q_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [IDX_W-1:0]        oldest_reg, oldest_next;
    logic [IDX_W-1:0]        rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]        lo_reg, lo_next;
    logic [IDX_W-1:0]        hi_reg, hi_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [TIME_W-1:0]       cur_t_reg, cur_t_next;
    logic signed [POS_W-1:0] cur_p_reg, cur_p_next;
    logic [TIME_W-1:0]       a_reg, a_next;
    logic [TIME_W-1:0]       d_reg, d_next;
    logic [MAG_W-1:0]        mag_reg, mag_next;
    logic                    neg_reg, neg_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic [TIME_W-1:0]       rem_reg, rem_next;
    logic [MAG_W-1:0]        quo_reg, quo_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic [1:0]              res_st_reg, res_st_next;
    logic signed [POS_W-1:0] res_p_reg, res_p_next;
    logic [TIME_W-1:0]       res_t_reg, res_t_next;
    logic [CNT_W-1:0]        res_i_reg, res_i_next;
    logic                    out_valid_reg;
    logic [1:0]              out_st_reg;
    logic signed [POS_W-1:0] out_p_reg;
    logic [TIME_W-1:0]       out_t_reg;
    logic [CNT_W-1:0]        out_i_reg;
    logic [CNT_W-1:0]        out_c_reg;

    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [ENTRY_W-1:0]      ram_rdata;
    logic [TIME_W-1:0]       rd_t;
    logic signed [POS_W-1:0] rd_p;
    logic                    out_free;
    logic                    load_out;
    logic [IDX_W-1:0]        mid;
    logic [IDX_W:0]          idx_inc;
    logic signed [MAG_W-1:0] dp;
    logic [TIME_W:0]         r2;
    logic [MAG_W-1:0]        interp;

    // Ring slot of a logical index
    function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] base,
                                              input logic [IDX_W-1:0] i);
        logic [IDX_W:0] s;
        s = {1'b0, base} + {1'b0, i};
        if (s >= DEPTH_V)
        begin
            s = s - DEPTH_V;
        end
        return s[IDX_W-1:0];
    endfunction

    phi_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({head.entry_time, head.entry_position}),
        .raddr (slot(oldest_reg, rd_idx_next)),
        .rdata (ram_rdata)
    );

    assign rd_t     = ram_rdata[ENTRY_W-1:POS_W];
    assign rd_p     = ram_rdata[POS_W-1:0];
    assign out_free = !out_valid_reg || !result_stall;
    assign load_out = (state_reg == S_FIN) && out_free;
    assign mid      = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign idx_inc  = {1'b0, idx_reg} + 1'b1;
    assign r2       = {rem_reg, prod_reg[PROD_W-1]};
    assign interp   = neg_reg ? (MAG_W'(cur_p_reg) - quo_reg) : (MAG_W'(cur_p_reg) + quo_reg);

    // Append write happens on dispatch
    assign ram_we    = (state_reg == S_IDLE) && head_valid && (head.kind == CMD_APPEND)
                       && (count_reg != FULL_V);
    assign ram_waddr = slot(oldest_reg, count_reg[IDX_W-1:0]);
    assign pop       = (state_reg == S_IDLE) && head_valid;

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        q_next      = q_reg;
        count_next  = count_reg;
        oldest_next = oldest_reg;
        rd_idx_next = rd_idx_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        idx_next    = idx_reg;
        cur_t_next  = cur_t_reg;
        cur_p_next  = cur_p_reg;
        a_next      = a_reg;
        d_next      = d_reg;
        mag_next    = mag_reg;
        neg_next    = neg_reg;
        prod_next   = prod_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        step_next   = step_reg;
        res_st_next = res_st_reg;
        res_p_next  = res_p_reg;
        res_t_next  = res_t_reg;
        res_i_next  = res_i_reg;
        dp          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (head_valid)
                begin
                    cmd_next    = head.kind;
                    q_next      = head.query_time;
                    res_st_next = ST_OK;
                    res_p_next  = '0;
                    res_t_next  = '0;
                    res_i_next  = '0;
                    unique case (head.kind)
                        CMD_APPEND:
                        begin
                            if (count_reg == FULL_V)
                            begin
                                res_st_next = ST_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + 1'b1;
                            end
                            state_next = S_FIN;
                        end
                        CMD_LOOKUP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_st_next = ST_NOT_FOUND;
                                state_next  = S_FIN;
                            end
                            else
                            begin
                                rd_idx_next = IDX_W'(count_reg - 1'b1);
                                state_next  = S_L_NEW;
                            end
                        end
                        CMD_FIND, CMD_DISCARD:
                        begin
                            if (count_reg == '0)
                            begin
                                res_st_next = ST_NOT_FOUND;
                                state_next  = S_FIN;
                            end
                            else
                            begin
                                rd_idx_next = '0;
                                state_next  = S_F_FST;
                            end
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end

            // Newest entry: query zero or later returns it
            S_L_NEW:
            begin
                if ((q_reg == '0) || (q_reg > rd_t))
                begin
                    res_p_next = rd_p;
                    res_t_next = rd_t;
                    state_next = S_FIN;
                end
                else
                begin
                    rd_idx_next = '0;
                    state_next  = S_L_OLD;
                end
            end

            // Oldest entry: earlier queries return it
            S_L_OLD:
            begin
                if (q_reg < rd_t)
                begin
                    res_p_next = rd_p;
                    res_t_next = rd_t;
                    state_next = S_FIN;
                end
                else
                begin
                    lo_next    = '0;
                    hi_next    = IDX_W'(count_reg - 1'b1);
                    state_next = S_L_BIS;
                end
            end

            // Bisection decision
            S_L_BIS:
            begin
                if (32'(hi_reg - lo_reg) > SPAN_LIMIT)
                begin
                    rd_idx_next = mid;
                    idx_next    = mid;
                    state_next  = S_L_MID;
                end
                else if (lo_reg == hi_reg)
                begin
                    rd_idx_next = lo_reg;
                    state_next  = S_L_HIT;
                end
                else
                begin
                    rd_idx_next = lo_reg;
                    state_next  = S_L_SC0;
                end
            end

            S_L_MID:
            begin
                if (rd_t == q_reg)
                begin
                    res_p_next = rd_p;
                    res_t_next = rd_t;
                    state_next = S_FIN;
                end
                else
                begin
                    if (rd_t < q_reg)
                    begin
                        lo_next = idx_reg;
                    end
                    else
                    begin
                        hi_next = idx_reg;
                    end
                    state_next = S_L_BIS;
                end
            end

            S_L_HIT:
            begin
                res_p_next = rd_p;
                res_t_next = rd_t;
                state_next = S_FIN;
            end

            // Scan start: hold the entry at lo, fetch the next one
            S_L_SC0:
            begin
                cur_t_next  = rd_t;
                cur_p_next  = rd_p;
                idx_next    = lo_reg;
                rd_idx_next = lo_reg + 1'b1;
                state_next  = S_L_SC;
            end

            // Linear scan over the remaining span
            S_L_SC:
            begin
                if ((cur_t_reg <= q_reg) && (idx_inc < {1'b0, hi_reg}) && (rd_t <= q_reg))
                begin
                    cur_t_next  = rd_t;
                    cur_p_next  = rd_p;
                    idx_next    = idx_inc[IDX_W-1:0];
                    rd_idx_next = IDX_W'(idx_inc + 1'b1);
                end
                else if (rd_t <= cur_t_reg)
                begin
                    res_st_next = ST_BAD_DELTA;
                    state_next  = S_FIN;
                end
                else
                begin
                    dp         = MAG_W'(rd_p) - MAG_W'(cur_p_reg);
                    neg_next   = dp[MAG_W-1];
                    mag_next   = dp[MAG_W-1] ? MAG_W'(-dp) : MAG_W'(dp);
                    a_next     = q_reg - cur_t_reg;
                    d_next     = rd_t - cur_t_reg;
                    prod_next  = '0;
                    step_next  = '0;
                    state_next = S_MUL;
                end
            end

            // Shift-add multiply, one magnitude bit a cycle, MSB first
            S_MUL:
            begin
                prod_next = {prod_reg[PROD_W-2:0], 1'b0}
                            + (mag_reg[MAG_W-1] ? PROD_W'(a_reg) : '0);
                mag_next  = {mag_reg[MAG_W-2:0], 1'b0};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(MAG_W - 1))
                begin
                    step_next  = '0;
                    state_next = S_DIV;
                end
                if (step_reg == STEP_W'(MAG_W - 1))
                begin
                    rem_next  = prod_next[PROD_W-1:MAG_W];
                    prod_next = {prod_next[MAG_W-1:0], TIME_W'(0)};
                    quo_next  = '0;
                end
            end

            // Restoring divide; the quotient fits in MAG_W bits
            S_DIV:
            begin
                if (r2 >= {1'b0, d_reg})
                begin
                    rem_next = TIME_W'(r2 - {1'b0, d_reg});
                    quo_next = {quo_reg[MAG_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = r2[TIME_W-1:0];
                    quo_next = {quo_reg[MAG_W-2:0], 1'b0};
                end
                prod_next = {prod_reg[PROD_W-2:0], 1'b0};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(MAG_W - 1))
                begin
                    state_next = S_INTERP;
                end
            end

            S_INTERP:
            begin
                res_p_next = interp[POS_W-1:0];
                res_t_next = q_reg;
                state_next = S_FIN;
            end

            // Find: first entry must not be after the query
            S_F_FST:
            begin
                idx_next = '0;
                if (rd_t > q_reg)
                begin
                    res_st_next = ST_NOT_FOUND;
                    state_next  = S_FIN;
                end
                else if (count_reg == CNT_W'(1))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    rd_idx_next = IDX_W'(1);
                    state_next  = S_F_NXT;
                end
            end

            S_F_NXT:
            begin
                if (rd_t > q_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    idx_next = idx_inc[IDX_W-1:0];
                    if ((CNT_W'(idx_inc) + 1'b1) >= count_reg)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        rd_idx_next = IDX_W'(idx_inc + 1'b1);
                    end
                end
            end

            // Hand the result to the output register once it is free
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Find result: index, or drop the older entries
        if (((state_reg == S_F_FST) || (state_reg == S_F_NXT)) && (state_next == S_FIN)
            && (res_st_next == ST_OK))
        begin
            if (cmd_reg == CMD_DISCARD)
            begin
                oldest_next = slot(oldest_reg, idx_next);
                count_next  = count_reg - CNT_W'(idx_next);
            end
            else
            begin
                res_i_next = CNT_W'(idx_next);
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            oldest_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            oldest_reg <= oldest_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working and result payload
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        q_reg      <= q_next;
        rd_idx_reg <= rd_idx_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        idx_reg    <= idx_next;
        cur_t_reg  <= cur_t_next;
        cur_p_reg  <= cur_p_next;
        a_reg      <= a_next;
        d_reg      <= d_next;
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        prod_reg   <= prod_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        step_reg   <= step_next;
        res_st_reg <= res_st_next;
        res_p_reg  <= res_p_next;
        res_t_reg  <= res_t_next;
        res_i_reg  <= res_i_next;
        if (load_out)
        begin
            out_st_reg <= res_st_reg;
            out_p_reg  <= res_p_reg;
            out_t_reg  <= res_t_reg;
            out_i_reg  <= res_i_reg;
            out_c_reg  <= count_reg;
        end
    end

    assign result_valid    = out_valid_reg;
    assign status          = out_st_reg;
    assign result_position = out_p_reg;
    assign result_time     = out_t_reg;
    assign found_index     = out_i_reg;
    assign entry_count     = out_c_reg;

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for position_history_interpolator.
// Depends on phi_pkg and the RTL; a directed table, then random command beats
// checked against an in-bench history predictor.
module testbench;
    import phi_pkg::*;

    localparam int DEPTH      = 64;
    localparam int IDLE_LIMIT = 20000;

    typedef struct {
        logic [1:0]        status;
        logic [31:0]       position;
        logic [TIME_W-1:0] rtime;
        logic [6:0]        index;
        logic [6:0]        count;
    } answer_t;

    typedef struct {
        logic [1:0]        cmd;
        logic [TIME_W-1:0] etime;
        logic [31:0]       epos;
        logic [TIME_W-1:0] qtime;
        bit                typed;
        answer_t           ans;
    } row_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cmd_valid = 1'b0;
    logic                     cmd_stall;
    logic [1:0]               command = CMD_APPEND;
    logic [TIME_W-1:0]        entry_time = '0;
    logic signed [POS_W-1:0]  entry_position = '0;
    logic [TIME_W-1:0]        query_time = '0;
    logic                     result_valid;
    logic                     result_stall = 1'b0;
    logic [1:0]               status;
    logic signed [POS_W-1:0]  result_position;
    logic [TIME_W-1:0]        result_time;
    logic [6:0]               found_index;
    logic [6:0]               entry_count;

    // predictor state: ring of entries
    logic [TIME_W-1:0] hist_time [DEPTH];
    logic [31:0]       hist_pos [DEPTH];
    logic [5:0]        oldest;
    int                held;

    answer_t pending_answers[$];
    row_t    directed[$];
    int      errors = 0;
    int      idle_cycles = 0;
    int      burst_left = 0;
    logic [TIME_W-1:0] next_time = 63'd1000;

    position_history_interpolator DUT (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
        .command(command), .entry_time(entry_time),
        .entry_position(entry_position), .query_time(query_time),
        .result_valid(result_valid), .result_stall(result_stall),
        .status(status), .result_position(result_position),
        .result_time(result_time), .found_index(found_index),
        .entry_count(entry_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [TIME_W-1:0] time_of(int i);
        return hist_time[6'(oldest + i)];
    endfunction

    function automatic longint pos_of(int i);
        return longint'($signed(hist_pos[6'(oldest + i)]));
    endfunction

    // Interpolated lookup over the held entries
    function automatic void lookup_history(logic [TIME_W-1:0] q, ref answer_t a);
        int lo, hi, mid, idx;
        logic [TIME_W-1:0] ta, tb;
        longint pa, pb, dp;
        logic [63:0] dq, mag;
        logic [127:0] quo;
        if (held == 0)
        begin
            a.status = ST_NOT_FOUND;
            return;
        end
        lo = 0;
        hi = held - 1;
        if (q == 0 || q > time_of(hi))
            lo = hi;
        else if (q < time_of(0))
            hi = 0;
        else
        begin
            while (hi - lo > SPAN_LIMIT)
            begin
                mid = lo + (hi - lo) / 2;
                if (time_of(mid) == q)
                begin
                    lo = mid;
                    hi = mid;
                    break;
                end
                if (time_of(mid) < q)
                    lo = mid;
                else
                    hi = mid;
            end
        end
        if (lo == hi)
        begin
            a.position = 32'(pos_of(lo));
            a.rtime = time_of(lo);
            return;
        end
        // linear scan of the remaining span
        idx = lo;
        while (time_of(idx) <= q && idx + 1 < hi && time_of(idx + 1) <= q)
            idx++;
        ta = time_of(idx);
        tb = time_of(idx + 1);
        if (tb <= ta)
        begin
            a.status = ST_BAD_DELTA;
            return;
        end
        pa = pos_of(idx);
        pb = pos_of(idx + 1);
        dp = pb - pa;
        mag = dp < 0 ? 64'(-dp) : 64'(dp);
        dq = {1'b0, q} - {1'b0, ta};
        quo = (128'(dq) * 128'(mag)) / 128'(tb - ta);
        a.position = dp < 0 ? 32'(pa - longint'(quo[63:0])) : 32'(pa + longint'(quo[63:0]));
        a.rtime = q;
    endfunction

    // Advance the predictor by one command beat
    function automatic answer_t predict_history(logic [1:0] cmd, logic [TIME_W-1:0] et,
                                                logic [31:0] ep, logic [TIME_W-1:0] q);
        answer_t a;
        int f;
        bit hit;
        a = '{ST_OK, 32'd0, '0, 7'd0, 7'd0};
        if (cmd == CMD_APPEND)
        begin
            if (held >= DEPTH)
                a.status = ST_FULL;
            else
            begin
                hist_time[6'(oldest + held)] = et;
                hist_pos[6'(oldest + held)] = ep;
                held++;
            end
        end
        else if (cmd == CMD_LOOKUP)
        begin
            lookup_history(q, a);
            if (a.status != ST_OK)
            begin
                a.position = '0;
                a.rtime = '0;
            end
        end
        else
        begin
            hit = 0;
            f = 0;
            for (int i = 0; i < held; i++)
            begin
                if (time_of(i) > q)
                    break;
                if (i + 1 >= held || time_of(i + 1) > q)
                begin
                    hit = 1;
                    f = i;
                    break;
                end
            end
            if (!hit)
                a.status = ST_NOT_FOUND;
            else if (cmd == CMD_DISCARD)
            begin
                oldest = 6'(oldest + f);
                held -= f;
            end
            else
                a.index = 7'(f);
        end
        a.count = 7'(held);
        return a;
    endfunction

    // Drive one beat; returns at the edge where it is taken
    task automatic send_beat(logic [1:0] cmd, logic [TIME_W-1:0] et, logic [31:0] ep,
                             logic [TIME_W-1:0] q, bit typed, answer_t typed_ans);
        answer_t a;
        if (burst_left == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 4))
                @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        cmd_valid <= 1'b1;
        command <= cmd;
        entry_time <= et;
        entry_position <= ep;
        query_time <= q;
        do
            @(posedge clk);
        while (cmd_stall);
        a = predict_history(cmd, et, ep, q);
        pending_answers = {pending_answers, (typed ? typed_ans : a)};
    endtask

    function automatic void add_row(logic [1:0] cmd, logic [TIME_W-1:0] et, logic [31:0] ep,
                                    logic [TIME_W-1:0] q, bit typed, logic [1:0] st,
                                    logic [31:0] p, logic [TIME_W-1:0] t, int idx, int cnt);
        row_t r;
        r.cmd = cmd;
        r.etime = et;
        r.epos = ep;
        r.qtime = q;
        r.typed = typed;
        r.ans = '{st, p, t, 7'(idx), 7'(cnt)};
        directed = {directed, r};
    endfunction

    function automatic logic [TIME_W-1:0] rand_time();
        return TIME_W'({$urandom, $urandom});
    endfunction

    // Query near or on the held times, with some off-range picks
    function automatic logic [TIME_W-1:0] pick_query();
        logic [TIME_W-1:0] first, last, span;
        int sel;
        sel = $urandom_range(0, 9);
        if (held == 0 || sel == 0)
            return rand_time();
        first = time_of(0);
        last = time_of(held - 1);
        case (sel)
            1: return '0;
            2: return last + $urandom_range(1, 100);
            3: return first > 0 ? first - $urandom_range(1, first > 100 ? 100 : first) : first;
            4, 5: return time_of($urandom_range(0, held - 1));
            default:
            begin
                if (last <= first)
                    return time_of($urandom_range(0, held - 1));
                span = last - first;
                return first + (rand_time() % (span + 1));
            end
        endcase
    endfunction

    // Receiver stall pattern, drawn at random from four modes over the run
    int stall_mode = 0;
    int cyc = 0;
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc % 256 == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: result_stall <= 1'b0;
            1: result_stall <= ($urandom_range(0, 9) < 3);
            2: result_stall <= ($urandom_range(0, 9) < 7);
            default: result_stall <= (cyc % 8) < 3;
        endcase
    end

    // Result checker
    always @(posedge clk)
    begin
        answer_t e;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_answers.size() == 0)
            begin
                $display("%0t: result beat with nothing pending", $time);
                errors++;
            end
            else
            begin
                e = pending_answers.pop_front();
                if (status !== e.status || result_position !== e.position ||
                    result_time !== e.rtime || found_index !== e.index ||
                    entry_count !== e.count)
                begin
                    $display("%0t: mismatch expected st=%0d pos=%h t=%h idx=%0d cnt=%0d",
                             $time, e.status, e.position, e.rtime, e.index, e.count);
                    $display("%0t:          actual   st=%0d pos=%h t=%h idx=%0d cnt=%0d",
                             $time, status, result_position, result_time, found_index,
                             entry_count);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no beat moving
    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    initial
    begin
        int sent;
        int phase;
        int n;
        logic [1:0] cmd;
        logic [TIME_W-1:0] et;
        logic [31:0] ep;
        answer_t none;
        oldest = '0;
        held = 0;
        none = '{ST_OK, 32'd0, '0, 7'd0, 7'd0};
        for (int i = 0; i < DEPTH; i++)
        begin
            hist_time[i] = '0;
            hist_pos[i] = '0;
        end

        // directed table
        add_row(CMD_LOOKUP, 0, 0, 50, 1, ST_NOT_FOUND, 0, 0, 0, 0);
        add_row(CMD_FIND, 0, 0, 50, 1, ST_NOT_FOUND, 0, 0, 0, 0);
        add_row(CMD_DISCARD, 0, 0, 50, 1, ST_NOT_FOUND, 0, 0, 0, 0);
        add_row(CMD_APPEND, 100, 32'h0001_0000, 0, 1, ST_OK, 0, 0, 0, 1);
        add_row(CMD_LOOKUP, 0, 0, 77, 1, ST_OK, 32'h0001_0000, 100, 0, 1);
        add_row(CMD_APPEND, 200, 32'hFFFF_0000, 0, 1, ST_OK, 0, 0, 0, 2);
        add_row(CMD_LOOKUP, 0, 0, 150, 0, ST_OK, 0, 0, 0, 0);
        add_row(CMD_LOOKUP, 0, 0, 0, 1, ST_OK, 32'hFFFF_0000, 200, 0, 2);
        add_row(CMD_LOOKUP, 0, 0, 999, 1, ST_OK, 32'hFFFF_0000, 200, 0, 2);
        add_row(CMD_LOOKUP, 0, 0, 100, 0, ST_OK, 0, 0, 0, 0);
        add_row(CMD_APPEND, 300, 32'h7FFF_FFFF, 0, 1, ST_OK, 0, 0, 0, 3);
        add_row(CMD_APPEND, 400, 32'h8000_0000, 0, 1, ST_OK, 0, 0, 0, 4);
        add_row(CMD_LOOKUP, 0, 0, 350, 0, ST_OK, 0, 0, 0, 0);
        add_row(CMD_APPEND, 400, 32'h0000_0005, 0, 1, ST_OK, 0, 0, 0, 5);
        add_row(CMD_LOOKUP, 0, 0, 400, 1, ST_BAD_DELTA, 0, 0, 0, 5);
        add_row(CMD_FIND, 0, 0, 250, 1, ST_OK, 0, 0, 1, 5);
        add_row(CMD_FIND, 0, 0, 50, 1, ST_NOT_FOUND, 0, 0, 0, 5);
        add_row(CMD_DISCARD, 0, 0, 250, 1, ST_OK, 0, 0, 0, 4);
        add_row(CMD_APPEND, {TIME_W{1'b1}}, 32'h0, 0, 1, ST_OK, 0, 0, 0, 5);
        add_row(CMD_LOOKUP, 0, 0, {TIME_W{1'b1}}, 0, ST_OK, 0, 0, 0, 0);
        add_row(CMD_LOOKUP, 0, 0, {{(TIME_W-4){1'b1}}, 4'h0}, 0, ST_OK, 0, 0, 0, 0);
        add_row(CMD_DISCARD, 0, 0, {TIME_W{1'b1}}, 1, ST_OK, 0, 0, 0, 1);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_beat(directed[i].cmd, directed[i].etime, directed[i].epos,
                      directed[i].qtime, directed[i].typed, directed[i].ans);

        // random phases: fill to full, mixed traffic, or noise
        sent = 0;
        phase = 0;
        while (sent < 1000)
        begin
            int kind;
            kind = $urandom_range(0, 4);
            if (held > 0)
                next_time = time_of(held - 1) + 1;
            if (next_time[TIME_W-1])
                next_time = 63'd1000;
            n = kind == 0 ? 80 : $urandom_range(20, 60);
            for (int k = 0; k < n; k++)
            begin
                int r;
                r = $urandom_range(0, 99);
                if (kind == 4)
                    cmd = 2'($urandom);
                else if (kind == 0)
                    cmd = r < 85 ? CMD_APPEND : (r < 95 ? CMD_LOOKUP : CMD_FIND);
                else
                    cmd = r < 35 ? CMD_APPEND : r < 75 ? CMD_LOOKUP : r < 92 ? CMD_FIND
                                                                     : CMD_DISCARD;
                r = $urandom_range(0, 99);
                if (kind == 4 || r < 5)
                    et = rand_time();
                else if (r < 10 && held > 0)
                    et = time_of(held - 1);
                else
                begin
                    next_time = next_time + $urandom_range(1, 5000);
                    et = next_time;
                end
                ep = $urandom;
                send_beat(cmd, et, ep, kind == 4 ? rand_time() : pick_query(), 0, none);
                sent++;
            end
            // on every fifth phase, hold off until every pending answer is in
            if (phase % 5 == 2)
            begin
                cmd_valid <= 1'b0;
                burst_left = 0;
                while (pending_answers.size() != 0)
                    @(posedge clk);
            end
            phase++;
        end

        cmd_valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule

[filelist.f]
rtl/phi_pkg.sv
rtl/phi_ram.sv
rtl/phi_front.sv
rtl/phi_back.sv
rtl/position_history_interpolator.sv
sim/testbench.sv
